// File: rtl/core/niat_pkg.sv
// ----------------------------------------------------------------------------
// niat_pkg
// Shared types, constants and helpers of the node ID association table.
// ----------------------------------------------------------------------------
package niat_pkg;

   localparam int NIAT_TABLE_SLOTS = 8;

   localparam int OP_W       = 3;
   localparam int ID_W       = 64;
   localparam int SLOT_W     = 8;
   localparam int LEN_W      = 4;
   localparam int IDX_OUT_W  = 4;
   localparam int ID_BYTES   = 8;
   localparam logic [7:0] EMPTY_MARK = 8'hFF;

   // request tdata layout, lowest bit first
   localparam int REQ_OP_LO     = 0;
   localparam int REQ_ID_LO     = REQ_OP_LO + OP_W;
   localparam int REQ_SLOT_LO   = REQ_ID_LO + ID_W;
   localparam int REQ_PREFIX_LO = REQ_SLOT_LO + SLOT_W;
   localparam int REQ_LEN_LO    = REQ_PREFIX_LO + ID_W;
   localparam int REQ_BITS      = REQ_LEN_LO + LEN_W;
   localparam int REQ_W         = ((REQ_BITS + 7) / 8) * 8;

   // response tdata layout, lowest bit first
   localparam int RSP_OK_LO    = 0;
   localparam int RSP_IDX_LO   = RSP_OK_LO + 1;
   localparam int RSP_ID_LO    = RSP_IDX_LO + IDX_OUT_W;
   localparam int RSP_CNT_LO   = RSP_ID_LO + ID_W;
   localparam int RSP_BITS     = RSP_CNT_LO + IDX_OUT_W;
   localparam int RSP_W        = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 3'd0,
      OP_ADD   = 3'd1,
      OP_COUNT = 3'd2,
      OP_GET   = 3'd3,
      OP_FIND  = 3'd4
   } op_type;

   typedef struct packed {
      logic capture;
      logic set_ok;
      logic do_clear;
      logic do_add;
      logic scan_step;
      logic scan_done;
      logic get_read;
      logic get_take;
      logic find_start;
      logic find_read;
      logic find_next;
      logic find_hit;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   room;
      logic   new_empty;
      logic   get_valid;
      logic   find_valid;
      logic   ptr_stop;
      logic   match;
      logic   out_free;
   } sts_type;

   function automatic logic [ID_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [ID_W-1:0] mask;
      mask = '0;
      for (int b = 0; b < ID_BYTES; b++) begin
         if (LEN_W'(b) < len) begin
            mask[ID_W-1-8*b -: 8] = 8'hFF;
         end
      end
      return mask;
   endfunction

endpackage

// File: rtl/core/niat_ram.sv
// ----------------------------------------------------------------------------
// niat_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module niat_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/niat_ctrl.sv
// ----------------------------------------------------------------------------
// niat_ctrl
// Operation sequencer: decodes each item and steps the datapath.
// ----------------------------------------------------------------------------
module niat_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  niat_pkg::sts_type sts,
   output niat_pkg::cmd_type cmd
);
   import niat_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_ADD_SCAN = 6'b000010,
      ST_GET_RD   = 6'b000100,
      ST_FIND_RD  = 6'b001000,
      ST_FIND_CMP = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DONE;
               case (sts.op)
                  OP_CLEAR: begin
                     cmd.do_clear = 1'b1;
                     cmd.set_ok   = 1'b1;
                  end
                  OP_ADD: begin
                     if (sts.room) begin
                        cmd.do_add = 1'b1;
                        if (!sts.new_empty) begin
                           state_in = ST_ADD_SCAN;
                        end
                     end
                  end
                  OP_COUNT: begin
                     cmd.set_ok = 1'b1;
                  end
                  OP_GET: begin
                     if (sts.get_valid) begin
                        cmd.get_read = 1'b1;
                        state_in     = ST_GET_RD;
                     end
                  end
                  OP_FIND: begin
                     if (sts.find_valid) begin
                        cmd.find_start = 1'b1;
                        state_in       = ST_FIND_RD;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ADD_SCAN: begin
            if (sts.ptr_stop) begin
               cmd.scan_done = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_GET_RD: begin
            cmd.get_take = 1'b1;
            state_in     = ST_DONE;
         end
         ST_FIND_RD: begin
            if (sts.ptr_stop) begin
               state_in = ST_DONE;
            end else begin
               cmd.find_read = 1'b1;
               state_in      = ST_FIND_CMP;
            end
         end
         ST_FIND_CMP: begin
            if (sts.match) begin
               cmd.find_hit = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.find_next = 1'b1;
               state_in      = ST_FIND_RD;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start an operation");

   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND_CMP) |-> ($past(state_ff) == ST_FIND_RD))
      else $error("find compare without a preceding read");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (sts.out_free && (state_ff == ST_DONE)))
      else $error("result loaded over a pending result");

endmodule

// File: rtl/core/niat_dp.sv
// ----------------------------------------------------------------------------
// niat_dp
// Datapath: ID store, empty flags, first-empty count, walk pointer and
// result registers.
// ----------------------------------------------------------------------------
module niat_dp #(
   parameter int TABLE_SLOTS = niat_pkg::NIAT_TABLE_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [niat_pkg::REQ_W-1:0] req_tdata,
   input  niat_pkg::cmd_type          cmd,
   output niat_pkg::sts_type          sts,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [niat_pkg::RSP_W-1:0] rsp_tdata
);
   import niat_pkg::*;

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

   logic [OP_W-1:0]   req_op;
   logic [ID_W-1:0]   req_id;
   logic [SLOT_W-1:0] req_slot;
   logic [ID_W-1:0]   req_prefix;
   logic [LEN_W-1:0]  req_len;

   assign req_op     = req_tdata[REQ_OP_LO     +: OP_W];
   assign req_id     = req_tdata[REQ_ID_LO     +: ID_W];
   assign req_slot   = req_tdata[REQ_SLOT_LO   +: SLOT_W];
   assign req_prefix = req_tdata[REQ_PREFIX_LO +: ID_W];
   assign req_len    = req_tdata[REQ_LEN_LO    +: LEN_W];

   logic [TABLE_SLOTS-1:0] empty_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       ptr_ff;
   logic [ID_W-1:0]        prefix_ff;
   logic [LEN_W-1:0]       len_ff;

   logic                   res_ok_ff;
   logic [IDX_OUT_W-1:0]   res_idx_ff;
   logic [ID_W-1:0]        res_id_ff;
   logic                   res_ok_in;
   logic [IDX_OUT_W-1:0]   res_idx_in;
   logic [ID_W-1:0]        res_id_in;

   logic                   out_valid_ff;
   logic [RSP_W-1:0]       out_data_ff;
   logic [RSP_W-1:0]       out_data_in;

   logic [ID_W-1:0]        rd_data;
   logic [IDX_W-1:0]       rd_addr;
   logic                   rd_en;

   logic [CNT_W+IDX_OUT_W-1:0] count_wide;
   logic [CNT_W+IDX_OUT_W-1:0] ptr_wide;

   assign count_wide = {{IDX_OUT_W{1'b0}}, count_ff};
   assign ptr_wide   = {{IDX_OUT_W{1'b0}}, ptr_ff};

   assign rd_en   = cmd.get_read | cmd.find_read;
   assign rd_addr = cmd.get_read ? req_slot[IDX_W-1:0] : ptr_ff[IDX_W-1:0];

   niat_ram #(
      .WIDTH (ID_W),
      .DEPTH (TABLE_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.do_add),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_id),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      sts            = '0;
      sts.op         = op_type'(req_op);
      sts.room       = (count_ff != CNT_W'(TABLE_SLOTS));
      sts.new_empty  = (req_id[ID_W-1 -: 8] == EMPTY_MARK);
      sts.get_valid  = ({1'b0, req_slot} < (SLOT_W+1)'(count_ff));
      sts.find_valid = ({1'b0, req_slot} < (SLOT_W+1)'(TABLE_SLOTS)) &&
                       (req_len <= LEN_W'(ID_BYTES));
      sts.ptr_stop   = (ptr_ff == CNT_W'(TABLE_SLOTS)) || empty_ff[ptr_ff[IDX_W-1:0]];
      sts.match      = (((rd_data ^ prefix_ff) & prefix_mask(len_ff)) == '0);
      sts.out_free   = !out_valid_ff || rsp_tready;
   end

   // table state
   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= '1;
         count_ff <= '0;
      end else begin
         if (cmd.do_clear) begin
            empty_ff <= '1;
            count_ff <= '0;
         end
         if (cmd.do_add) begin
            empty_ff[count_ff[IDX_W-1:0]] <= sts.new_empty;
         end
         if (cmd.scan_done) begin
            count_ff <= ptr_ff;
         end
      end
   end

   // walk pointer and request fields
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prefix_ff <= req_prefix;
         len_ff    <= req_len;
      end
      if (cmd.do_add) begin
         ptr_ff <= count_ff + CNT_W'(1);
      end else if (cmd.scan_step || cmd.find_next) begin
         ptr_ff <= ptr_ff + CNT_W'(1);
      end else if (cmd.find_start) begin
         ptr_ff <= req_slot[CNT_W-1:0];
      end
   end

   // result
   always_comb begin
      res_ok_in  = res_ok_ff;
      res_idx_in = res_idx_ff;
      res_id_in  = res_id_ff;
      if (cmd.capture) begin
         res_ok_in  = 1'b0;
         res_idx_in = '0;
         res_id_in  = '0;
      end
      if (cmd.set_ok || cmd.do_add || cmd.get_take || cmd.find_hit) begin
         res_ok_in = 1'b1;
      end
      if (cmd.do_add) begin
         res_idx_in = count_wide[IDX_OUT_W-1:0];
      end
      if (cmd.get_take) begin
         res_id_in = rd_data;
      end
      if (cmd.find_hit) begin
         res_idx_in = ptr_wide[IDX_OUT_W-1:0];
         res_id_in  = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      res_ok_ff  <= res_ok_in;
      res_idx_ff <= res_idx_in;
      res_id_ff  <= res_id_in;
   end

   // result holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      out_data_in                          = '0;
      out_data_in[RSP_OK_LO]               = res_ok_ff;
      out_data_in[RSP_IDX_LO +: IDX_OUT_W] = res_idx_ff;
      out_data_in[RSP_ID_LO  +: ID_W]      = res_id_ff;
      out_data_in[RSP_CNT_LO +: IDX_OUT_W] = count_wide[IDX_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: rtl/core/node_id_association_table.sv
// Path to rsp_tvalid: clear, count, add to a full table or of an ID marked empty, rejected
//   get or find and unknown codes go straight to the done state; get first reads the RAM.
// Other adds walk the occupied entries behind the new one up to the next empty slot or end.
// Find reads and compares entries from slot_index until a match, an empty entry or the end.
// One item at a time; the next is taken once the result sits in the output register.
// Reset marks every entry empty and the count zero; the ID RAM itself is not cleared.
// ----------------------------------------------------------------------------
// node_id_association_table
// Table of 8-byte node IDs with clear, add, count, get and prefix find.
// ----------------------------------------------------------------------------
module node_id_association_table #(
   parameter int TABLE_SLOTS = niat_pkg::NIAT_TABLE_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // operation[2:0], new_id[66:3], slot_index[74:67], prefix_bytes[138:75],
   // prefix_len[142:139], zero[143]
   input  logic [niat_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // ok[0], found_index[4:1], entry_id[68:5], entry_count[72:69], zero[79:73]
   output logic [niat_pkg::RSP_W-1:0] rsp_tdata
);
   import niat_pkg::*;

   cmd_type cmd;
   sts_type sts;

   niat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   niat_dp #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
